>>> rtl/gtp_pkg.sv
// Shared constants, register indexes and types of the Goertzel tone power detector.
package gtp_pkg;

    // Operands of the shared multiplier are cut into 32-bit chunks plus a sign bit.
    localparam int CHUNK_W    = 32;
    localparam int MUL_W      = CHUNK_W + 1;
    // Chunk position within the accumulator; covers products of up to 128 bits.
    localparam int POS_W      = 2;

    // Fixed-point formats.
    localparam int FRAC_W     = 16;
    localparam int OUT_SHIFT  = 48;

    // Configuration register widths.
    localparam int COEF_W     = 19;
    localparam int TRIG_W     = 18;
    localparam int SCALE_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_FEEDBACK  = 3'd0,
        REG_COS_END_PHASE  = 3'd1,
        REG_COS_NEXT_PHASE = 3'd2,
        REG_SIN_END_PHASE  = 3'd3,
        REG_SIN_NEXT_PHASE = 3'd4,
        REG_NORM_SCALE     = 3'd5
    } t_reg_idx;

    // Control that travels with one product through the multiply-accumulate unit.
    typedef struct packed {
        logic             issue;
        logic             clr;
        logic             sub;
        logic [POS_W-1:0] pos;
    } t_mac_ctl;

endpackage

>>> rtl/gtp_cfg_if.sv
// Configuration write channel of the Goertzel tone power detector.
interface gtp_cfg_if import gtp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/gtp_sample_if.sv
// Sample input channel of the Goertzel tone power detector.
interface gtp_sample_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           is_last;

    modport source (output valid, sample, is_last, input ready);
    modport sink (input valid, sample, is_last, output ready);
endinterface

>>> rtl/gtp_result_if.sv
// Result output channel of the Goertzel tone power detector.
interface gtp_result_if #(
    parameter int STATE_WIDTH = 48
) ();
    logic                   valid;
    logic                   ready;
    logic [STATE_WIDTH-1:0] strength;

    modport source (output valid, strength, input ready);
    modport sink (input valid, strength, output ready);
endinterface

>>> rtl/gtp_mac.sv
// Shared chunked multiply-accumulate unit with rounding and saturation of the accumulator.
module gtp_mac import gtp_pkg::*; #(
    parameter int STATE_WIDTH = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mac_ctl                      i_ctl,
    input  logic signed [MUL_W-1:0]       i_a,
    input  logic signed [MUL_W-1:0]       i_b,
    output logic signed [STATE_WIDTH-1:0] o_rnd_state,
    output logic [STATE_WIDTH-1:0]        o_rnd_out,
    output logic [2*STATE_WIDTH-1:0]      o_pwr
);

    localparam int ACC_W = 2 * STATE_WIDTH + 34;
    localparam int RS_W  = ACC_W - FRAC_W;
    localparam int RO_W  = ACC_W - OUT_SHIFT;
    localparam logic [STATE_WIDTH-1:0] S_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic [STATE_WIDTH-1:0] S_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

    t_mac_ctl                   r_ctl;
    logic signed [2*MUL_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    prod_sh;
    logic signed [ACC_W-1:0]    acc_base;
    logic signed [ACC_W-1:0]    rnd_s_sum;
    logic signed [ACC_W-1:0]    rnd_o_sum;
    logic signed [RS_W-1:0]     rnd_s;
    logic signed [RO_W-1:0]     rnd_o;
    logic [RS_W-STATE_WIDTH:0]  s_hi;
    logic [RO_W-STATE_WIDTH-1:0] o_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // The product is registered before it is shifted into place and accumulated.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_ctl.issue) begin
            r_acc <= r_ctl.sub ? (acc_base - prod_sh) : (acc_base + prod_sh);
        end
    end

    always_comb begin
        prod_sh  = ACC_W'(r_prod) <<< (CHUNK_W * r_ctl.pos);
        acc_base = r_ctl.clr ? '0 : r_acc;
    end

    // Round half up by 16 bits and saturate to the signed state width.
    always_comb begin
        rnd_s_sum = r_acc + (ACC_W'(1) <<< (FRAC_W - 1));
        rnd_s     = RS_W'(rnd_s_sum >>> FRAC_W);
        s_hi      = rnd_s[RS_W-1:STATE_WIDTH-1];
        if ((&s_hi) || !(|s_hi)) begin
            o_rnd_state = rnd_s[STATE_WIDTH-1:0];
        end else if (rnd_s[RS_W-1]) begin
            o_rnd_state = S_MIN;
        end else begin
            o_rnd_state = S_MAX;
        end
    end

    // Round half up by 48 bits and saturate to the unsigned output width.
    always_comb begin
        rnd_o_sum = r_acc + (ACC_W'(1) <<< (OUT_SHIFT - 1));
        rnd_o     = RO_W'(rnd_o_sum >>> OUT_SHIFT);
        o_hi      = rnd_o[RO_W-1:STATE_WIDTH];
        if (rnd_o[RO_W-1]) begin
            o_rnd_out = '0;
        end else if (|o_hi) begin
            o_rnd_out = '1;
        end else begin
            o_rnd_out = rnd_o[STATE_WIDTH-1:0];
        end
    end

    assign o_pwr = r_acc[2*STATE_WIDTH-1:0];

endmodule

>>> rtl/goertzel_tone_power.sv
// Top level of the generalised Goertzel single-bin tone power detector.
// Ordinary and last samples alike are worked through the one shared 33x33 multiplier.
// Reset is synchronous and clears the recurrence, the coefficients and the result beat.
module goertzel_tone_power import gtp_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 48
) (
    input  logic i_clk,
    input  logic i_rst_n,
    gtp_cfg_if.sink       i_cfg,
    gtp_sample_if.sink    i_smp,
    gtp_result_if.source  o_res
);

    // Number of 32-bit chunks in a state value and in the power value.
    localparam int NCH = (STATE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int PCH = (2 * STATE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam logic [POS_W-1:0] NCH_LAST = POS_W'(NCH - 1);
    localparam logic [POS_W-1:0] PCH_LAST = POS_W'(PCH - 1);
    localparam logic signed [MUL_W-1:0] FRAC_ONE = MUL_W'(2 ** FRAC_W);

    // Terms of the sum that one phase builds in the accumulator.
    localparam logic [1:0] TERM_A = 2'd0;
    localparam logic [1:0] TERM_B = 2'd1;
    localparam logic [1:0] TERM_C = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_ROUND = 4'b1000
    } t_state;

    typedef enum logic [4:0] {
        PH_REC = 5'b00001,
        PH_T1  = 5'b00010,
        PH_T2  = 5'b00100,
        PH_SQ  = 5'b01000,
        PH_SCL = 5'b10000
    } t_phase;

    t_state r_state;
    t_phase r_phase;
    logic [1:0]       r_term;
    logic [POS_W-1:0] r_ci;
    logic [POS_W-1:0] r_cj;

    // Configuration registers.
    logic signed [COEF_W-1:0] r_coef;
    logic signed [TRIG_W-1:0] r_cos_d;
    logic signed [TRIG_W-1:0] r_cos_ad;
    logic signed [TRIG_W-1:0] r_sin_d;
    logic signed [TRIG_W-1:0] r_sin_ad;
    logic [SCALE_W-1:0]       r_scale;

    // Recurrence state and working values.
    logic signed [STATE_WIDTH-1:0]  r_s1;
    logic signed [STATE_WIDTH-1:0]  r_s2;
    logic signed [STATE_WIDTH-1:0]  r_s0;
    logic signed [STATE_WIDTH-1:0]  r_y1;
    logic signed [STATE_WIDTH-1:0]  r_y2;
    logic [2*STATE_WIDTH-1:0]       r_pwr;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic                           r_last;

    // Result register.
    logic                   r_out_vld;
    logic [STATE_WIDTH-1:0] r_strength;

    logic smp_acc;
    logic out_free;

    t_mac_ctl                      mac_ctl;
    logic signed [MUL_W-1:0]       mac_a;
    logic signed [MUL_W-1:0]       mac_b;
    logic signed [STATE_WIDTH-1:0] rnd_state;
    logic [STATE_WIDTH-1:0]        rnd_out;
    logic [2*STATE_WIDTH-1:0]      pwr;

    logic [1:0]                    lim_term;
    logic [POS_W-1:0]              lim_i;
    logic [POS_W-1:0]              lim_j;
    logic signed [STATE_WIDTH-1:0] sq_vec;

    // Chunk k of a signed state value: the top chunk carries the sign, the others are
    // zero-extended, so the chunk products sum to the full product.
    function automatic logic signed [MUL_W-1:0] f_chunk(
        input logic signed [STATE_WIDTH-1:0] v,
        input logic [POS_W-1:0]              k
    );
        logic signed [NCH*CHUNK_W-1:0] vext;
        logic                          top;
        vext = (NCH*CHUNK_W)'(v);
        top  = (k == NCH_LAST) && vext[NCH*CHUNK_W-1];
        return {top, vext[k*CHUNK_W +: CHUNK_W]};
    endfunction

    // Chunk k of the unsigned power value.
    function automatic logic signed [MUL_W-1:0] f_pchunk(
        input logic [2*STATE_WIDTH-1:0] v,
        input logic [POS_W-1:0]         k
    );
        logic [PCH*CHUNK_W-1:0] pext;
        pext = (PCH*CHUNK_W)'(v);
        return {1'b0, pext[k*CHUNK_W +: CHUNK_W]};
    endfunction

    assign smp_acc     = i_smp.valid && i_smp.ready;
    assign i_smp.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_out_vld || o_res.ready;
    assign o_res.valid    = r_out_vld;
    assign o_res.strength = r_strength;

    // Configuration writes. Indexes past the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= '0;
            r_cos_d  <= '0;
            r_cos_ad <= '0;
            r_sin_d  <= '0;
            r_sin_ad <= '0;
            r_scale  <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_COEF_FEEDBACK:  r_coef   <= i_cfg.data[COEF_W-1:0];
                REG_COS_END_PHASE:  r_cos_d  <= i_cfg.data[TRIG_W-1:0];
                REG_COS_NEXT_PHASE: r_cos_ad <= i_cfg.data[TRIG_W-1:0];
                REG_SIN_END_PHASE:  r_sin_d  <= i_cfg.data[TRIG_W-1:0];
                REG_SIN_NEXT_PHASE: r_sin_ad <= i_cfg.data[TRIG_W-1:0];
                REG_NORM_SCALE:     r_scale  <= i_cfg.data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Operand selection. Each phase is a sum of terms; each term is a product of
    // chunked operands, and the counters walk its chunks one product per cycle.
    //   recurrence: x*2^32 + B*s1 - s2*2^16
    //   first arm:  s0*cosD - s1*cosAD
    //   second arm: s1*sinAD - s0*sinD
    //   squares:    y1*y1 + y2*y2
    //   scaling:    p*scale
    always_comb begin
        mac_a         = '0;
        mac_b         = '0;
        mac_ctl.issue = (r_state == S_ISSUE);
        mac_ctl.clr   = (r_term == TERM_A) && (r_ci == '0) && (r_cj == '0);
        mac_ctl.sub   = 1'b0;
        mac_ctl.pos   = r_ci;
        lim_term      = TERM_B;
        lim_i         = NCH_LAST;
        lim_j         = '0;
        sq_vec        = r_y1;
        unique case (r_phase)
            PH_REC: begin
                lim_term = TERM_C;
                case (r_term)
                    TERM_A: begin
                        // The sample lands one chunk up, which is x*2^32.
                        lim_i       = '0;
                        mac_a       = MUL_W'(r_x);
                        mac_b       = MUL_W'(1);
                        mac_ctl.pos = POS_W'(1);
                    end
                    TERM_B: begin
                        mac_a = f_chunk(r_s1, r_ci);
                        mac_b = MUL_W'(r_coef);
                    end
                    default: begin
                        mac_a       = f_chunk(r_s2, r_ci);
                        mac_b       = FRAC_ONE;
                        mac_ctl.sub = 1'b1;
                    end
                endcase
            end
            PH_T1: begin
                if (r_term == TERM_A) begin
                    mac_a = f_chunk(r_s0, r_ci);
                    mac_b = MUL_W'(r_cos_d);
                end else begin
                    mac_a       = f_chunk(r_s1, r_ci);
                    mac_b       = MUL_W'(r_cos_ad);
                    mac_ctl.sub = 1'b1;
                end
            end
            PH_T2: begin
                if (r_term == TERM_A) begin
                    mac_a = f_chunk(r_s1, r_ci);
                    mac_b = MUL_W'(r_sin_ad);
                end else begin
                    mac_a       = f_chunk(r_s0, r_ci);
                    mac_b       = MUL_W'(r_sin_d);
                    mac_ctl.sub = 1'b1;
                end
            end
            PH_SQ: begin
                lim_j       = NCH_LAST;
                sq_vec      = (r_term == TERM_A) ? r_y1 : r_y2;
                mac_a       = f_chunk(sq_vec, r_ci);
                mac_b       = f_chunk(sq_vec, r_cj);
                mac_ctl.pos = POS_W'(r_ci + r_cj);
            end
            PH_SCL: begin
                lim_term = TERM_A;
                lim_i    = PCH_LAST;
                mac_a    = f_pchunk(r_pwr, r_ci);
                mac_b    = {1'b0, r_scale};
            end
            default: ;
        endcase
    end

    // Sequencer: issue every product of a phase, let the last one drain into the
    // accumulator, then round and move the result to where the next phase wants it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_REC;
            r_term    <= TERM_A;
            r_ci      <= '0;
            r_cj      <= '0;
            r_s1      <= '0;
            r_s2      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (smp_acc) begin
                        r_state <= S_ISSUE;
                        r_phase <= PH_REC;
                    end
                end
                S_ISSUE: begin
                    if (r_cj == lim_j) begin
                        r_cj <= '0;
                        if (r_ci == lim_i) begin
                            r_ci <= '0;
                            if (r_term == lim_term) begin
                                r_term  <= TERM_A;
                                r_state <= S_DRAIN;
                            end else begin
                                r_term <= r_term + 2'd1;
                            end
                        end else begin
                            r_ci <= r_ci + POS_W'(1);
                        end
                    end else begin
                        r_cj <= r_cj + POS_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    unique case (r_phase)
                        PH_REC: begin
                            if (r_last) begin
                                r_phase <= PH_T1;
                                r_state <= S_ISSUE;
                            end else begin
                                r_s2    <= r_s1;
                                r_s1    <= rnd_state;
                                r_state <= S_IDLE;
                            end
                        end
                        PH_T1: begin
                            r_phase <= PH_T2;
                            r_state <= S_ISSUE;
                        end
                        PH_T2: begin
                            r_phase <= PH_SQ;
                            r_state <= S_ISSUE;
                        end
                        PH_SQ: begin
                            r_phase <= PH_SCL;
                            r_state <= S_ISSUE;
                        end
                        PH_SCL: begin
                            // Wait here while an earlier result beat is still held.
                            if (out_free) begin
                                r_s1      <= '0;
                                r_s2      <= '0;
                                r_state   <= S_IDLE;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The result beat is raised by the final rounding step of a last sample and dropped
    // once it has been taken; a new beat may replace one taken in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == S_ROUND && r_phase == PH_SCL && out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_res.valid && o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Working values carry no reset.
    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_x    <= i_smp.sample;
            r_last <= i_smp.is_last;
        end
        if (r_state == S_ROUND) begin
            if (r_phase == PH_REC) begin
                r_s0 <= rnd_state;
            end
            if (r_phase == PH_T1) begin
                r_y1 <= rnd_state;
            end
            if (r_phase == PH_T2) begin
                r_y2 <= rnd_state;
            end
            if (r_phase == PH_SQ) begin
                r_pwr <= pwr;
            end
            if (r_phase == PH_SCL && out_free) begin
                r_strength <= rnd_out;
            end
        end
    end

    gtp_mac #(
        .STATE_WIDTH (STATE_WIDTH)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mac_ctl),
        .i_a         (mac_a),
        .i_b         (mac_b),
        .o_rnd_state (rnd_state),
        .o_rnd_out   (rnd_out),
        .o_pwr       (pwr)
    );

`ifndef SYNTHESIS
    // A new result beat only ever follows the final rounding step of a last sample.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_ROUND && r_phase == PH_SCL))
        else $error("result beat raised outside the final rounding step");

    // The recurrence starts from zero after every result.
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_phase == PH_SCL && out_free)
        |=> (r_s1 == '0 && r_s2 == '0))
        else $error("recurrence not cleared after a result");

    // The chunk counters never run past the limits of the current phase.
    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> (r_ci <= lim_i && r_cj <= lim_j && r_term <= lim_term))
        else $error("chunk counter out of range");

    // An accepted sample always starts a fresh recurrence phase.
    a_sample_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        smp_acc |=> (r_state == S_ISSUE && r_phase == PH_REC && r_term == TERM_A
                     && r_ci == '0 && r_cj == '0))
        else $error("sample accepted without starting the recurrence");
`endif

endmodule

>>> tb/tb_goertzel_tone_power.sv
// Self-checking testbench for the Goertzel tone power detector, with a bit-exact predictor.
module tb_goertzel_tone_power import gtp_pkg::*; ();

    localparam int SAMPLE_W = 16;
    localparam int STATE_W  = 48;

    // Every product of the predictor is formed at this width, which holds the largest
    // intermediate (a 96-bit power times the 32-bit scale) with room to spare.
    typedef logic signed [191:0] t_wide;

    localparam t_wide STATE_MAX    = (t_wide'(1) <<< (STATE_W - 1)) - 1;
    localparam t_wide STATE_MIN    = -(t_wide'(1) <<< (STATE_W - 1));
    localparam t_wide STRENGTH_MAX = (t_wide'(1) <<< STATE_W) - 1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Register indexes past the end of the map; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Settling time, a little beyond what a last sample takes at this width.
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam real TWO_PI = 2.0 * 3.14159265358979323846;

    typedef enum int {FILL_TONE, FILL_OFF_BIN, FILL_NOISE, FILL_EXTREME} t_fill;

    logic i_clk;
    logic i_rst_n;

    gtp_cfg_if                                cfg_ch ();
    gtp_sample_if #(.SAMPLE_WIDTH(SAMPLE_W))  smp_ch ();
    gtp_result_if #(.STATE_WIDTH(STATE_W))    res_ch ();

    goertzel_tone_power #(
        .SAMPLE_WIDTH (SAMPLE_W),
        .STATE_WIDTH  (STATE_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_smp   (smp_ch),
        .o_res   (res_ch)
    );

    // Shadow copies of the coefficient registers, held at their hardware widths.
    logic [COEF_W-1:0]  r_coef;
    logic [TRIG_W-1:0]  r_cos_end;
    logic [TRIG_W-1:0]  r_cos_next;
    logic [TRIG_W-1:0]  r_sin_end;
    logic [TRIG_W-1:0]  r_sin_next;
    logic [SCALE_W-1:0] r_scale;

    // Recurrence pair of the predictor: s1 and s2 in Q32.16.
    logic signed [STATE_W-1:0] s_prev;
    logic signed [STATE_W-1:0] s_older;

    // Strengths predicted for the last samples accepted so far, oldest first.
    logic [STATE_W-1:0] strength_due [$];

    int  n_errors;
    int  n_samples;
    int  n_results;
    int  n_writes;
    int  quiet_cycles;
    int  idle_pct;
    bit  calm;
    bit  hold_req;
    int  tone_n;
    int  tone_k;

    int  bin_sizes [11] = '{2, 3, 4, 8, 12, 16, 20, 24, 32, 48, 64};

    // Clock with a period of 12 time units.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clamp to the signed state range.
    function automatic logic signed [STATE_W-1:0] sat_state(input t_wide v);
        if (v > STATE_MAX)
            return STATE_MAX[STATE_W-1:0];
        if (v < STATE_MIN)
            return STATE_MIN[STATE_W-1:0];
        return v[STATE_W-1:0];
    endfunction

    // Drop n fraction bits, rounding halves towards plus infinity.
    function automatic t_wide round_off(input t_wide v, input int n);
        return (v + (t_wide'(1) <<< (n - 1))) >>> n;
    endfunction

    // Advances the recurrence by one accepted sample. On a last sample it also forms the
    // phase-corrected power, scales and saturates it, queues it as the expected strength
    // and clears the pair, exactly as the hardware must.
    task automatic advance_goertzel(input logic signed [SAMPLE_W-1:0] x, input logic last);
        t_wide xw, s1w, s2w, s0w, bw, cdw, cadw, sdw, sadw, y1, y2, sc, acc;
        logic signed [STATE_W-1:0] s0;
        logic [STATE_W-1:0]        str;

        xw   = x;
        s1w  = s_prev;
        s2w  = s_older;
        bw   = $signed(r_coef);
        cdw  = $signed(r_cos_end);
        cadw = $signed(r_cos_next);
        sdw  = $signed(r_sin_end);
        sadw = $signed(r_sin_next);
        sc   = r_scale;

        // s0 = x + B*s1 - s2, all held with 32 fraction bits before the one rounding.
        acc = (xw <<< 32) + bw * s1w - (s2w <<< FRAC_W);
        s0  = sat_state(round_off(acc, FRAC_W));

        if (!last) begin
            s_older = s_prev;
            s_prev  = s0;
            return;
        end

        s0w = s0;
        y1  = sat_state(round_off(s0w * cdw - s1w * cadw, FRAC_W));
        y2  = sat_state(round_off(s1w * sadw - s0w * sdw, FRAC_W));
        acc = round_off((y1 * y1 + y2 * y2) * sc, OUT_SHIFT);

        if (acc < 0)
            str = '0;
        else if (acc > STRENGTH_MAX)
            str = STRENGTH_MAX[STATE_W-1:0];
        else
            str = acc[STATE_W-1:0];

        strength_due.push_back(str);
        s_prev  = '0;
        s_older = '0;
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [STATE_W-1:0] got,
                                 input logic [STATE_W-1:0] want);
        n_errors++;
        $display("mismatch (%s) at %0t: got %h, expected %h", what, $time, got, want);
    endtask

    // Writes one register and mirrors it in the shadow copy. The valid is left high so
    // that writes can follow back to back; the caller lowers it at the end of a burst.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        n_writes++;
        case (idx)
            REG_COEF_FEEDBACK:  r_coef     = data[COEF_W-1:0];
            REG_COS_END_PHASE:  r_cos_end  = data[TRIG_W-1:0];
            REG_COS_NEXT_PHASE: r_cos_next = data[TRIG_W-1:0];
            REG_SIN_END_PHASE:  r_sin_end  = data[TRIG_W-1:0];
            REG_SIN_NEXT_PHASE: r_sin_next = data[TRIG_W-1:0];
            REG_NORM_SCALE:     r_scale    = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    // Offers one sample beat, possibly after a random gap, and predicts on acceptance.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic last);
        if (!calm && $urandom_range(1, 100) <= idle_pct) begin
            smp_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        smp_ch.valid   <= 1'b1;
        smp_ch.sample  <= x;
        smp_ch.is_last <= last;
        do @(posedge i_clk); while (smp_ch.ready !== 1'b1);
        n_samples++;
        advance_goertzel(x, last);
    endtask

    // Stops offering samples, waits for every outstanding strength and then lets the
    // block finish any ordinary sample still in flight, so that registers may change.
    task automatic wait_idle();
        smp_ch.valid <= 1'b0;
        while (strength_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] clip_sample(input real v);
        if (v >= 32767.0)
            return SAMPLE_MAX;
        if (v <= -32768.0)
            return SAMPLE_MIN;
        return 16'(longint'(v));
    endfunction

    // Loads the coefficients that software would compute for bin k of an n-point block.
    task automatic configure_bin(input int n, input int k);
        real w, e;
        longint b;

        w = TWO_PI * k / n;
        e = w * (n - 1);
        b = longint'(2.0 * $cos(w) * 65536.0);
        if (b > 262143)
            b = 262143;
        tone_n = n;
        tone_k = k;
        write_reg(REG_COEF_FEEDBACK,  32'(b));
        write_reg(REG_COS_END_PHASE,  32'(longint'($cos(e) * 65536.0)));
        write_reg(REG_COS_NEXT_PHASE, 32'(longint'($cos(w + e) * 65536.0)));
        write_reg(REG_SIN_END_PHASE,  32'(longint'($sin(e) * 65536.0)));
        write_reg(REG_SIN_NEXT_PHASE, 32'(longint'($sin(w + e) * 65536.0)));
        write_reg(REG_NORM_SCALE,     32'(longint'(2.0 / (n * n) * 4294967296.0)));
        // Now and then poke the unmapped indexes as well; nothing may change.
        if ($urandom_range(0, 2) == 0) begin
            write_reg(REG_SPARE_LO, $urandom());
            write_reg(REG_SPARE_HI, $urandom());
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Sends blocks until about the given number of samples has gone. Most blocks are
    // whole blocks of the configured length; a few have odd lengths, and some carry
    // the last flag at random places so that blocks get cut short or run on.
    task automatic run_blocks(input int budget);
        int    used, len, i;
        t_fill fill;
        bit    ragged;
        real   amp, freq, ph;
        logic signed [SAMPLE_W-1:0] x;
        logic  last;

        used = 0;
        while (used < budget) begin
            len    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24) : tone_n;
            ragged = ($urandom_range(0, 6) == 0);
            fill   = t_fill'($urandom_range(0, 3));
            amp    = $urandom_range(0, 32767);
            freq   = (fill == FILL_TONE) ? tone_k : tone_k + $urandom_range(1, 7) / 3.0;
            ph     = $urandom_range(0, 359) * TWO_PI / 360.0;
            for (i = 0; i < len; i++) begin
                case (fill)
                    FILL_TONE, FILL_OFF_BIN:
                        x = clip_sample(amp * $sin(TWO_PI * freq * i / tone_n + ph)
                                        + $urandom_range(0, 200) - 100.0);
                    FILL_NOISE:
                        x = SAMPLE_W'($urandom());
                    default:
                        x = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                endcase
                last = ragged ? ($urandom_range(0, 5) == 0) : (i == len - 1);
                send_sample(x, last);
            end
            used += len;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, the long hold-off and the strength check.
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        logic [STATE_W-1:0] want;

        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                n_results++;
                if (strength_due.size() == 0) begin
                    flag_mismatch("strength beat with nothing pending", res_ch.strength, '0);
                end else begin
                    want = strength_due.pop_front();
                    if (res_ch.strength !== want)
                        flag_mismatch("strength", res_ch.strength, want);
                end
            end
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(1, 200) <= idle_pct) begin
                stall_left = $urandom_range(0, 15);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Ends the run if no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((smp_ch.valid === 1'b1 && smp_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("no beat on any channel for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // With every register at its reset value of zero the scale kills any power.
    task automatic test_register_reset();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample('0, 1'b1);
        wait_idle();
    endtask

    // Coefficients at the limits of their fields, some beyond the nominal trig range,
    // drive the recurrence, both magnitude terms and the scaled power into saturation.
    // A second setting uses the most negative feedback with the smallest non-zero scale.
    task automatic test_saturation();
        int i;

        write_reg(REG_COEF_FEEDBACK,  32'h0003_ffff);
        write_reg(REG_COS_END_PHASE,  32'h0001_ffff);
        write_reg(REG_COS_NEXT_PHASE, 32'hfffe_0000);
        write_reg(REG_SIN_END_PHASE,  32'hffff_0000);
        write_reg(REG_SIN_NEXT_PHASE, 32'h0001_0000);
        write_reg(REG_NORM_SCALE,     32'hffff_ffff);
        cfg_ch.valid <= 1'b0;
        for (i = 0; i < 10; i++)
            send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        wait_idle();

        write_reg(REG_COEF_FEEDBACK,  32'hfffc_0000);
        write_reg(REG_COS_END_PHASE,  32'h0001_0000);
        write_reg(REG_COS_NEXT_PHASE, 32'hffff_0000);
        write_reg(REG_SIN_END_PHASE,  32'h0000_0000);
        write_reg(REG_SIN_NEXT_PHASE, 32'h0001_0000);
        write_reg(REG_NORM_SCALE,     32'h0000_0001);
        cfg_ch.valid <= 1'b0;
        for (i = 0; i < 6; i++)
            send_sample(i[0] ? SAMPLE_MAX : SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        wait_idle();
    endtask

    // Realistic bins over a range of block sizes, with varying amounts of idling.
    task automatic test_bin_sweep();
        int p, n;

        for (p = 0; p < 11; p++) begin
            n = bin_sizes[$urandom_range(0, 10)];
            configure_bin(n, $urandom_range(0, n / 2));
            idle_pct = 10 * $urandom_range(0, 4);
            run_blocks(85);
            wait_idle();
        end
    endtask

    // Arbitrary register contents: every data bit toggles and the state saturates often.
    task automatic test_random_registers();
        int p;

        for (p = 0; p < 3; p++) begin
            write_reg(REG_COEF_FEEDBACK,  $urandom());
            write_reg(REG_COS_END_PHASE,  $urandom());
            write_reg(REG_COS_NEXT_PHASE, $urandom());
            write_reg(REG_SIN_END_PHASE,  $urandom());
            write_reg(REG_SIN_NEXT_PHASE, $urandom());
            write_reg(REG_NORM_SCALE,     $urandom());
            cfg_ch.valid <= 1'b0;
            tone_n   = $urandom_range(2, 24);
            tone_k   = $urandom_range(0, tone_n / 2);
            idle_pct = 20;
            run_blocks(80);
            wait_idle();
        end
    endtask

    // The result side holds off for a long stretch while short blocks keep coming, so the
    // block has to hold its pending strength and push back on the sample channel.
    task automatic test_backpressure();
        int b, i;

        configure_bin(4, 1);
        idle_pct = 0;
        hold_req = 1'b1;
        for (b = 0; b < 8; b++) begin
            for (i = 0; i < 3; i++)
                send_sample(SAMPLE_W'($urandom()), i == 2);
        end
        wait_idle();
    endtask

    // The closing stretch runs with no idling on either side.
    task automatic test_no_idling();
        int p, n;

        calm = 1'b1;
        for (p = 0; p < 2; p++) begin
            n = bin_sizes[$urandom_range(0, 10)];
            configure_bin(n, $urandom_range(0, n / 2));
            run_blocks(85);
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        n_errors     = 0;
        n_samples    = 0;
        n_results    = 0;
        n_writes     = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        tone_n       = 16;
        tone_k       = 1;
        r_coef       = '0;
        r_cos_end    = '0;
        r_cos_next   = '0;
        r_sin_end    = '0;
        r_sin_next   = '0;
        r_scale      = '0;
        s_prev       = '0;
        s_older      = '0;

        i_rst_n        <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= '0;
        cfg_ch.data    <= '0;
        smp_ch.valid   <= 1'b0;
        smp_ch.sample  <= '0;
        smp_ch.is_last <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_reset();
        test_saturation();
        test_bin_sweep();
        test_random_registers();
        test_backpressure();
        test_no_idling();

        $display("covered %0d samples and %0d register writes over tone, noise, saturating",
                 n_samples, n_writes);
        $display("and random settings, with stalls and a long hold-off; %0d strengths checked",
                 n_results);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/gtp_pkg.sv
rtl/gtp_cfg_if.sv
rtl/gtp_sample_if.sv
rtl/gtp_result_if.sv
rtl/gtp_mac.sv
rtl/goertzel_tone_power.sv
tb/tb_goertzel_tone_power.sv
